@@ sv/lse_pkg.sv @@
`default_nettype none

package lse_pkg;

    localparam int DEPTH  = 64;
    localparam int WORD_W = 32;
    localparam int LEN_W  = 7;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef enum logic [2:0] {
        CMD_PUSH     = 3'd0,
        CMD_POP      = 3'd1,
        CMD_PEEK     = 3'd2,
        CMD_CLEAR    = 3'd3,
        CMD_TRAVERSE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP,
        OP_ROTATE,
        OP_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        word_t    word;
    } chain_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_TRAV
    } state_t;

endpackage

`default_nettype wire

@@ sv/lse_cell.sv @@
`default_nettype none

module lse_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  lse_pkg::cell_op_t op,
    input  lse_pkg::word_t    prev_word,
    input  logic              prev_occ,
    input  lse_pkg::word_t    next_word,
    input  logic              next_occ,
    output lse_pkg::word_t    word,
    output logic              occ,
    output lse_pkg::word_t    tap_word
);
    import lse_pkg::*;

    word_t word_reg;
    word_t word_next;
    logic  occ_reg;
    logic  occ_next;

    always_comb begin
        word_next = word_reg;
        occ_next  = occ_reg;
        unique case (op)
            OP_HOLD: begin
            end
            OP_PUSH: begin
                word_next = prev_word;
                occ_next  = prev_occ;
            end
            OP_POP: begin
                word_next = next_word;
                occ_next  = next_occ;
            end
            OP_ROTATE: begin
                if (occ_reg) begin
                    word_next = prev_word;
                end
            end
            OP_CLEAR: begin
                occ_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    // The cell drives the bottom tap only when it is the deepest occupied one.
    assign word     = word_reg;
    assign occ      = occ_reg;
    assign tap_word = (occ_reg && !next_occ) ? word_reg : '0;

endmodule

`default_nettype wire

@@ sv/lse_chain.sv @@
`default_nettype none

module lse_chain (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lse_pkg::chain_ctrl_t ctrl,
    output lse_pkg::word_t       top_word,
    output lse_pkg::word_t       bottom_word
);
    import lse_pkg::*;

    word_t word_w [DEPTH];
    logic  occ_w  [DEPTH];
    word_t tap_w  [DEPTH];
    word_t head_word;
    word_t bottom_or;

    assign head_word = (ctrl.op == OP_ROTATE) ? bottom_or : ctrl.word;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        word_t pw;
        word_t nw;
        logic  po;
        logic  no;

        if (i == 0) begin : g_head
            assign pw = head_word;
            assign po = 1'b1;
        end else begin : g_prev
            assign pw = word_w[i-1];
            assign po = occ_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign nw = '0;
            assign no = 1'b0;
        end else begin : g_next
            assign nw = word_w[i+1];
            assign no = occ_w[i+1];
        end

        lse_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (ctrl.op),
            .prev_word (pw),
            .prev_occ  (po),
            .next_word (nw),
            .next_occ  (no),
            .word      (word_w[i]),
            .occ       (occ_w[i]),
            .tap_word  (tap_w[i])
        );
    end

    always_comb begin
        bottom_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            bottom_or = bottom_or | tap_w[k];
        end
    end

    assign top_word    = word_w[0];
    assign bottom_word = bottom_or;

endmodule

`default_nettype wire

@@ sv/lifo_stack_engine_unit.sv @@
// LIFO stack of signed 32-bit words built as a row of cells, the top word in
// the first cell. Commands arrive on the slave stream: s_tuser carries the
// command and s_tdata the word to push. Every command gives at least one
// result beat on the master stream, with the value in m_tdata, the status in
// m_tuser and m_tlast set on the final beat of the command.
// For push, pop, peek, clear and the unused codes the result is registered
// and appears in the cycle after the command beat, and a new command is
// taken every cycle while the receiver keeps up.
// Traverse of a stack of N words gives N beats, bottom word first, one per
// cycle; the occupied cells rotate by one place per beat and are back in
// their original order after the last one. No command is taken meanwhile.
// After reset the stack is empty and no result is pending. When the receiver
// holds m_tready low the result register keeps its beat, s_tready falls and a
// running traverse pauses without losing its place.
`default_nettype none

module lifo_stack_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // push_value [31:0]
    input  logic [2:0]  s_tuser,   // command [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_value [31:0], stack_length [38:32], is_empty [39]
    output logic [1:0]  m_tuser,   // status [1:0]
    output logic        m_tlast    // last_of_run
);
    import lse_pkg::*;

    localparam len_t FULL_LEN = LEN_W'(DEPTH);
    localparam len_t LEN_ONE  = LEN_W'(1);

    state_t      state_reg;
    state_t      state_next;
    len_t        len_reg;
    len_t        len_next;
    len_t        cnt_reg;
    len_t        cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    word_t       out_value_reg;
    word_t       out_value_next;
    status_t     out_status_reg;
    status_t     out_status_next;
    len_t        out_len_reg;
    len_t        out_len_next;
    logic        out_last_reg;
    logic        out_last_next;

    chain_ctrl_t ctrl;
    word_t       top_word;
    word_t       bottom_word;
    logic        out_free;
    logic        in_fire;
    cmd_t        cmd;

    lse_chain u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .top_word    (top_word),
        .bottom_word (bottom_word)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        ctrl.op         = OP_HOLD;
        ctrl.word       = s_tdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = STATUS_OK;
                    out_last_next   = 1'b1;
                    unique case (cmd)
                        CMD_PUSH: begin
                            if (len_reg == FULL_LEN) begin
                                out_status_next = STATUS_FULL;
                            end else begin
                                ctrl.op        = OP_PUSH;
                                len_next       = len_reg + LEN_ONE;
                                out_value_next = s_tdata;
                            end
                        end
                        CMD_POP: begin
                            if (len_reg == '0) begin
                                out_status_next = STATUS_EMPTY;
                            end else begin
                                ctrl.op        = OP_POP;
                                len_next       = len_reg - LEN_ONE;
                                out_value_next = top_word;
                            end
                        end
                        CMD_PEEK: begin
                            if (len_reg == '0) begin
                                out_status_next = STATUS_EMPTY;
                            end else begin
                                out_value_next = top_word;
                            end
                        end
                        CMD_CLEAR: begin
                            ctrl.op  = OP_CLEAR;
                            len_next = '0;
                        end
                        CMD_TRAVERSE: begin
                            if (len_reg == '0) begin
                                out_status_next = STATUS_EMPTY;
                            end else begin
                                ctrl.op        = OP_ROTATE;
                                out_value_next = bottom_word;
                                cnt_next       = len_reg - LEN_ONE;
                                if (len_reg != LEN_ONE) begin
                                    out_last_next = 1'b0;
                                    state_next    = ST_TRAV;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    out_len_next = len_next;
                end
            end
            ST_TRAV: begin
                if (out_free) begin
                    ctrl.op         = OP_ROTATE;
                    out_valid_next  = 1'b1;
                    out_value_next  = bottom_word;
                    out_status_next = STATUS_OK;
                    out_len_next    = len_reg;
                    cnt_next        = cnt_reg - LEN_ONE;
                    out_last_next   = (cnt_reg == LEN_ONE);
                    if (cnt_reg == LEN_ONE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(out_len_reg == '0), out_len_reg, out_value_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= FULL_LEN)
        else $error("Stack length beyond depth.");

    a_trav_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TRAV |-> (cnt_reg != '0) && (cnt_reg < len_reg))
        else $error("Traverse count out of range.");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_status_reg == STATUS_FULL) |-> out_len_reg == FULL_LEN)
        else $error("Full status on a stack that is not full.");

    a_trav_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_last_reg |-> !in_fire)
        else $error("Command taken during a traverse run.");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import lse_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        word_t   word;
        status_t status;
        len_t    len;
        logic    empty;
        logic    last;
    } reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    word_t  stack_words [DEPTH];
    int     stack_fill = 0;
    reply_t due_replies [$];
    int     error_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_req = 1'b0;

    lifo_stack_engine_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void queue_reply(word_t word, status_t status, logic last);
        reply_t r;
        r.word   = word;
        r.status = status;
        r.len    = len_t'(stack_fill);
        r.empty  = (stack_fill == 0);
        r.last   = last;
        due_replies.push_back(r);
    endfunction

    function automatic void mirror_stack_command(logic [2:0] cmd, word_t val);
        case (cmd)
            CMD_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    queue_reply('0, STATUS_FULL, 1'b1);
                end else begin
                    stack_words[stack_fill] = val;
                    stack_fill++;
                    queue_reply(val, STATUS_OK, 1'b1);
                end
            end
            CMD_POP: begin
                if (stack_fill == 0) begin
                    queue_reply('0, STATUS_EMPTY, 1'b1);
                end else begin
                    stack_fill--;
                    queue_reply(stack_words[stack_fill], STATUS_OK, 1'b1);
                end
            end
            CMD_PEEK: begin
                if (stack_fill == 0) begin
                    queue_reply('0, STATUS_EMPTY, 1'b1);
                end else begin
                    queue_reply(stack_words[stack_fill-1], STATUS_OK, 1'b1);
                end
            end
            CMD_CLEAR: begin
                stack_fill = 0;
                queue_reply('0, STATUS_OK, 1'b1);
            end
            CMD_TRAVERSE: begin
                if (stack_fill == 0) begin
                    queue_reply('0, STATUS_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < stack_fill; i++) begin
                        queue_reply(stack_words[i], STATUS_OK, i == stack_fill - 1);
                    end
                end
            end
            default: begin
                queue_reply('0, STATUS_OK, 1'b1);
            end
        endcase
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(input logic [2:0] cmd, input word_t val);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        mirror_stack_command(cmd, val);
    endtask

    // The receiver stalls at random, or for one long stretch on request.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        reply_t got;
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.word   = m_tdata[31:0];
            got.status = status_t'(m_tuser);
            got.len    = m_tdata[38:32];
            got.empty  = m_tdata[39];
            got.last   = m_tlast;
            if (due_replies.size() == 0) begin
                error_count++;
                $display("%0t: unexpected beat: value %h status %0d length %0d empty %b last %b",
                         $time, got.word, got.status, got.len, got.empty, got.last);
            end else begin
                want = due_replies.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch: expected value %h status %0d length %0d empty %b last %b",
                             $time, want.word, want.status, want.len, want.empty, want.last);
                    $display("%0t:           got value %h status %0d length %0d empty %b last %b",
                             $time, got.word, got.status, got.len, got.empty, got.last);
                end
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("lifo_stack_engine_unit test failed");
        $finish;
    end

    task automatic test_empty_stack();
        send_command(CMD_POP, pick_word());
        send_command(CMD_PEEK, pick_word());
        send_command(CMD_TRAVERSE, pick_word());
        send_command(CMD_CLEAR, pick_word());
        for (logic [3:0] c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
            send_command(c[2:0], $urandom);
        end
    endtask

    task automatic test_word_extremes();
        send_command(CMD_PUSH, 32'h8000_0000);
        send_command(CMD_PUSH, 32'h7FFF_FFFF);
        send_command(CMD_PUSH, 32'h0000_0000);
        send_command(CMD_PUSH, 32'hFFFF_FFFF);
        send_command(CMD_PUSH, 32'h5555_5555);
        send_command(CMD_PUSH, 32'hAAAA_AAAA);
        send_command(CMD_PEEK, '0);
        send_command(CMD_TRAVERSE, '0);
        send_command(CMD_POP, '0);
        send_command(CMD_SPARE_LO, '0);
        send_command(CMD_POP, '0);
        send_command(CMD_PEEK, '0);
        send_command(CMD_CLEAR, '0);
        send_command(CMD_TRAVERSE, '0);
    endtask

    // The receiver holds off as the stack begins to fill, so the input stalls.
    task automatic test_full_stack();
        hold_req = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
            send_command(CMD_PUSH, pick_word());
        end
        send_command(CMD_PUSH, pick_word());
        send_command(CMD_PUSH, pick_word());
        send_command(CMD_PEEK, '0);
        send_command(CMD_TRAVERSE, '0);
        send_command(CMD_POP, '0);
        send_command(CMD_PUSH, pick_word());
        send_command(CMD_PEEK, '0);
        send_command(CMD_CLEAR, '0);
    endtask

    task automatic test_random_mix(input int n_items);
        int pick;
        logic [2:0] cmd;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                cmd = CMD_PUSH;
            end else if (pick < 65) begin
                cmd = CMD_POP;
            end else if (pick < 77) begin
                cmd = CMD_PEEK;
            end else if (pick < 89) begin
                cmd = CMD_TRAVERSE;
            end else if (pick < 95) begin
                cmd = CMD_CLEAR;
            end else begin
                cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            end
            send_command(cmd, pick_word());
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 54;
        test_empty_stack();
        test_word_extremes();
        test_full_stack();
        test_random_mix(13);

        send_idle_pct = 54;
        recv_idle_pct = 37;
        test_random_mix(12);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(12);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (due_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("lifo_stack_engine_unit test passed");
        end else begin
            $display("lifo_stack_engine_unit test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/lse_pkg.sv
sv/lse_cell.sv
sv/lse_chain.sv
sv/lifo_stack_engine_unit.sv
bench/tb_top.sv
